// ===== rtl/rit_pkg.sv =====
// Package with shared types and constants for the receive identifier index table.
`default_nettype none

package rit_pkg;

  localparam int IX_W   = 16;
  localparam int ID_W   = 32;
  localparam int FUNC_W = 2;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ASSIGN = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

  localparam logic RS_OK    = 1'b0;
  localparam logic RS_RANGE = 1'b1;

  localparam logic [1:0] REG_DUMMY_INDEX = 2'd0;
  localparam logic [1:0] REG_DUMMY_ID    = 2'd1;
  localparam logic [1:0] REG_ID_MASK     = 2'd2;

  localparam logic [IX_W-1:0] DUMMY_INDEX_RST = 16'h0000;
  localparam logic [ID_W-1:0] DUMMY_ID_RST    = 32'hFFFF_FFFF;
  localparam logic [ID_W-1:0] ID_MASK_RST     = 32'h0000_07FF;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   can_link;
    logic [IX_W-1:0]   index_value;
  } in_item_t;

  typedef struct packed {
    logic            status;
    logic [IX_W-1:0] found_index;
  } out_item_t;

  typedef struct packed {
    logic [IX_W-1:0] dummy_index;
    logic [ID_W-1:0] dummy_identifier;
    logic [ID_W-1:0] identifier_mask;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_SCAN,
    ST_TAIL,
    ST_STORE,
    ST_LOOK
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/rit_mem.sv =====
// Simple dual-port table memory with one write port and one registered read port.
`default_nettype none

module rit_mem
  import rit_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire logic [IX_W-1:0] wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output logic      [IX_W-1:0] rdata_r
);

  logic [IX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rit_cfg.sv =====
// Configuration register file with an APB-style access port.
`default_nettype none

module rit_cfg
  import rit_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_regs_t               cfg
);

  cfg_regs_t  cfg_r;
  cfg_regs_t  cfg_nxt;
  logic [1:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_DUMMY_INDEX: cfg_nxt.dummy_index      = pwdata[IX_W-1:0];
        REG_DUMMY_ID:    cfg_nxt.dummy_identifier = pwdata;
        REG_ID_MASK:     cfg_nxt.identifier_mask  = pwdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DUMMY_INDEX: prdata = {{(PDATA_W-IX_W){1'b0}}, cfg_r.dummy_index};
      REG_DUMMY_ID:    prdata = cfg_r.dummy_identifier;
      REG_ID_MASK:     prdata = cfg_r.identifier_mask;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dummy_index      <= DUMMY_INDEX_RST;
      cfg_r.dummy_identifier <= DUMMY_ID_RST;
      cfg_r.identifier_mask  <= ID_MASK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rit_ctrl.sv =====
// Sequencer that sweeps, scans, updates or reads the table memory as each command requires.
`default_nettype none

module rit_ctrl
  import rit_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire in_item_t        in_data,
  input  wire cfg_regs_t       cfg,
  output logic                 busy,
  output logic                 out_valid,
  output out_item_t            out_data,
  output logic                 mem_we,
  output logic      [AW-1:0]   mem_waddr,
  output logic      [IX_W-1:0] mem_wdata,
  output logic                 mem_re,
  output logic      [AW-1:0]   mem_raddr,
  input  wire logic [IX_W-1:0] mem_rdata
);

  localparam logic [AW-1:0]   LAST    = AW'(DEPTH - 1);
  localparam logic [ID_W-1:0] ENTRIES = ID_W'(DEPTH);

  state_t          state_r, state_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic [IX_W-1:0] ix_r, ix_nxt;
  logic [AW-1:0]   id_r, id_nxt;
  logic            skip_r, skip_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]   chk_addr_r, chk_addr_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;
  logic [ID_W-1:0] masked_id;
  logic            last;

  assign masked_id = in_data.can_link & cfg.identifier_mask;
  assign last      = (cnt_r == LAST);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ix_nxt        = ix_r;
    id_nxt        = id_r;
    skip_nxt      = skip_r;
    chk_vld_nxt   = 1'b0;
    chk_addr_nxt  = cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = cfg.dummy_index;
    mem_re        = 1'b0;
    mem_raddr     = cnt_r;
    case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = DUMMY_INDEX_RST;
        cnt_nxt   = cnt_r + AW'(1);
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          out_data_nxt = '0;
          case (in_data.func)
            FN_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = ST_FILL;
            end
            FN_ASSIGN: begin
              if (in_data.index_value == cfg.dummy_index) begin
                out_valid_nxt = 1'b1;
              end else if (masked_id >= ENTRIES) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = RS_RANGE;
              end else begin
                ix_nxt    = in_data.index_value;
                id_nxt    = masked_id[AW-1:0];
                skip_nxt  = (masked_id == cfg.dummy_identifier);
                cnt_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            FN_LOOKUP: begin
              if (in_data.can_link < ENTRIES) begin
                mem_re    = 1'b1;
                mem_raddr = in_data.can_link[AW-1:0];
                state_nxt = ST_LOOK;
              end else begin
                out_valid_nxt            = 1'b1;
                out_data_nxt.found_index = cfg.dummy_index;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_FILL: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (last) begin
          cnt_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        mem_re      = 1'b1;
        chk_vld_nxt = 1'b1;
        cnt_nxt     = cnt_r + AW'(1);
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_STORE;
      end
      ST_STORE: begin
        mem_we        = !skip_r;
        mem_waddr     = id_r;
        mem_wdata     = ix_r;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        state_nxt     = ST_IDLE;
      end
      ST_LOOK: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.status      = RS_OK;
        out_data_nxt.found_index = mem_rdata;
        state_nxt                = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // Entries that hold the index being assigned are released in the cycle after their read.
    if (chk_vld_r && (mem_rdata == ix_r)) begin
      mem_we    = 1'b1;
      mem_waddr = chk_addr_r;
      mem_wdata = cfg.dummy_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ix_r       <= ix_nxt;
    id_r       <= id_nxt;
    skip_r     <= skip_nxt;
    chk_addr_r <= chk_addr_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/receive_id_index_table.sv =====
// Top level of the receive identifier to object-dictionary index table.
//
// A command transaction is taken when start is high and busy is low; in_data
// carries func, can_link and index_value. Every command yields exactly one
// result, shown on out_data for one cycle while out_valid is high. The
// receiver cannot stall, so the result is always taken in that cycle.
// An early-ending assign, an out-of-range lookup and the unused code give
// their result from ST_IDLE; a table lookup reads memory and returns the
// entry from ST_LOOK; a clear writes every entry in ST_FILL; a scanning
// assign reads every entry in ST_SCAN, passes ST_TAIL and writes the new
// entry in ST_STORE. A clear or an assign is paced by the single write port
// of the table memory, which it visits one entry per cycle. The next command
// is taken once busy is low, while the last result may still be on the
// outputs. After reset the block sweeps the memory, writing the dummy index
// reset value into every entry, and keeps busy high for that time.
// Configuration writes on the APB-style port are accepted at any time.
`default_nettype none

module receive_id_index_table
  import rit_pkg::*;
#(
  parameter int TABLE_ENTRIES = 2048
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire in_item_t           in_data,
  output logic                    busy,
  output logic                    out_valid,
  output out_item_t               out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  cfg_regs_t       cfg;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [IX_W-1:0] mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [IX_W-1:0] mem_rdata;

  rit_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rit_ctrl #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cfg       (cfg),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  rit_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/rit_chk.sv =====
// Port-level checker for the receive identifier index table and its bind.
`default_nettype none

module rit_chk
  import rit_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire out_item_t out_data
);

  // The table is swept after every reset, so no command can be taken right away.
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy not raised after reset");

  // A clear transaction always occupies the block for the table sweep.
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.func == FN_CLEAR) |=> busy && !out_valid)
    else $error("clear transaction did not start a sweep");

  // A result only follows an accepted transaction or work in progress.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a transaction");

  // An out-of-range status never carries a lookup value.
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == RS_RANGE) |-> out_data.found_index == '0)
    else $error("range status with a nonzero index");

endmodule

bind receive_id_index_table rit_chk u_rit_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/receive_id_index_table_checker.sv =====
// Checker that predicts and compares every result of the receive identifier index table.
`timescale 1ns / 100ps

module receive_id_index_table_checker
  import rit_pkg::*;
#(
  parameter int TABLE_ENTRIES = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  in_item_t           in_data,
  input  logic               busy,
  input  logic               out_valid,
  input  out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 awaiting
);

  logic [IX_W-1:0] id_map [TABLE_ENTRIES];
  logic [IX_W-1:0] dummy_ix;
  logic [ID_W-1:0] dummy_id;
  logic [ID_W-1:0] id_mask;
  out_item_t       pending_replies [$];
  out_item_t       want;
  int              mismatches = 0;

  function automatic out_item_t resolve_command(input in_item_t cmd);
    out_item_t       r;
    logic [ID_W-1:0] masked;
    r      = '0;
    masked = cmd.can_link & id_mask;
    case (cmd.func)
      FN_CLEAR: begin
        foreach (id_map[k]) id_map[k] = dummy_ix;
      end
      FN_ASSIGN: begin
        if (cmd.index_value != dummy_ix) begin
          if (masked >= ID_W'(TABLE_ENTRIES)) begin
            r.status = RS_RANGE;
          end else begin
            foreach (id_map[k]) begin
              if (id_map[k] == cmd.index_value) id_map[k] = dummy_ix;
            end
            if (masked != dummy_id) id_map[masked] = cmd.index_value;
          end
        end
      end
      FN_LOOKUP: begin
        if (cmd.can_link < ID_W'(TABLE_ENTRIES)) r.found_index = id_map[cmd.can_link];
        else r.found_index = dummy_ix;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (id_map[k]) id_map[k] = DUMMY_INDEX_RST;
      dummy_ix = DUMMY_INDEX_RST;
      dummy_id = DUMMY_ID_RST;
      id_mask  = ID_MASK_RST;
      pending_replies.delete();
    end else begin
      if (out_valid) begin
        if (pending_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result status=%0d found_index=%h", $time,
                     out_data.status, out_data.found_index);
          end
        end else begin
          want = pending_replies.pop_front();
          if (out_data.status !== want.status ||
              out_data.found_index !== want.found_index) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: expected status=%0d index=%h, got status=%0d index=%h",
                       $time, want.status, want.found_index, out_data.status,
                       out_data.found_index);
            end
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_DUMMY_INDEX: dummy_ix = pwdata[IX_W-1:0];
          REG_DUMMY_ID:    dummy_id = pwdata[ID_W-1:0];
          REG_ID_MASK:     id_mask  = pwdata[ID_W-1:0];
          default: begin
          end
        endcase
      end
      if (start && !busy) pending_replies.push_back(resolve_command(in_data));
    end
    fail_count <= mismatches;
    awaiting   <= pending_replies.size();
  end

endmodule

// ===== tb/tb_receive_id_index_table.sv =====
// Top of the testbench: drives commands and register writes into the table and gives the verdict.
`timescale 1ns / 100ps

module tb_receive_id_index_table;
  import rit_pkg::*;

  localparam int               ENTRIES   = 2048;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               start;
  in_item_t           in_data;
  logic               busy;
  logic               out_valid;
  out_item_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 awaiting;
  bit                 steady = 1'b0;

  logic [IX_W-1:0] ix_pool [6] = '{16'h0000, 16'h0001, 16'h1234, 16'h8000, 16'hFFFF, 16'h00A5};

  receive_id_index_table #(
    .TABLE_ENTRIES(ENTRIES)
  ) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data), .busy(busy),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  receive_id_index_table_checker #(
    .TABLE_ENTRIES(ENTRIES)
  ) i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data), .busy(busy),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .awaiting(awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #7_000_000;
    $display("receive_id_index_table verification failed");
    $finish;
  end

  task automatic send(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] link,
                      input logic [IX_W-1:0] ix);
    in_item_t cmd;
    int       gap;
    cmd.func        = fn;
    cmd.can_link    = link;
    cmd.index_value = ix;
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
    gap = 0;
    if (!steady) begin
      while ($urandom_range(0, 99) < 12) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (awaiting != 0 || busy);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setup(input logic [IX_W-1:0] ix, input logic [ID_W-1:0] id,
                             input logic [ID_W-1:0] mask);
    settle();
    write_reg(REG_DUMMY_INDEX, PDATA_W'(ix));
    write_reg(REG_DUMMY_ID, id);
    write_reg(REG_ID_MASK, mask);
  endtask

  function automatic logic [IX_W-1:0] pick_index();
    if ($urandom_range(0, 99) < 80) return ix_pool[$urandom_range(0, 5)];
    return IX_W'($urandom);
  endfunction

  function automatic logic [ID_W-1:0] pick_link();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return ID_W'($urandom_range(0, 15));
    if (r < 80) return (ID_W'($urandom) << 11) | ID_W'($urandom_range(0, 15));
    if (r < 88) begin
      case ($urandom_range(0, 3))
        0:       return ID_W'(ENTRIES - 1);
        1:       return ID_W'(ENTRIES);
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return ID_W'($urandom);
  endfunction

  task automatic run_random(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 45) send(FN_ASSIGN, pick_link(), pick_index());
      else if (r < 85) send(FN_LOOKUP, pick_link(), IX_W'($urandom));
      else if (r < 92) send(FN_CLEAR, ID_W'($urandom), IX_W'($urandom));
      else if (r < 96) send(FN_UNUSED, ID_W'($urandom), IX_W'($urandom));
      else send(FN_ASSIGN, ID_W'($urandom), IX_W'($urandom));
    end
  endtask

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    send(FN_LOOKUP, 32'd0, 16'h0000);
    send(FN_LOOKUP, 32'd2047, 16'hFFFF);
    send(FN_LOOKUP, 32'd2048, 16'h0000);
    send(FN_ASSIGN, 32'd3, 16'h0000);
    send(FN_ASSIGN, 32'd3, 16'h1111);
    send(FN_ASSIGN, 32'd7, 16'h1111);
    send(FN_LOOKUP, 32'd3, 16'h0000);
    send(FN_LOOKUP, 32'd7, 16'h0000);
    send(FN_ASSIGN, 32'hFFFF_F805, 16'hFFFF);
    send(FN_LOOKUP, 32'd5, 16'h0000);
    send(FN_LOOKUP, 32'hFFFF_F805, 16'h0000);
    send(FN_ASSIGN, 32'd2047, 16'h8000);
    send(FN_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
    send(FN_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    send(FN_CLEAR, 32'd0, 16'h0000);
    send(FN_LOOKUP, 32'd7, 16'h0000);

    apply_setup(16'hFFFF, 32'd9, 32'hFFFF_FFFF);
    send(FN_ASSIGN, 32'h0000_0800, 16'h2222);
    send(FN_ASSIGN, 32'd4, 16'h2222);
    send(FN_ASSIGN, 32'd9, 16'h2222);
    send(FN_LOOKUP, 32'd4, 16'h0000);
    send(FN_LOOKUP, 32'd9, 16'h0000);
    send(FN_ASSIGN, 32'd100, 16'hFFFF);
    send(FN_LOOKUP, 32'd100, 16'h0000);
    send(FN_LOOKUP, 32'd3000, 16'h0000);
    send(FN_CLEAR, 32'd0, 16'h0000);
    send(FN_LOOKUP, 32'd100, 16'h0000);

    apply_setup(16'h0000, 32'hFFFF_FFFF, 32'h0000_07FF);
    run_random(70);
    apply_setup(16'hFFFF, ID_W'($urandom_range(0, 15)), 32'hFFFF_FFFF);
    steady = 1'b1;
    run_random(70);
    steady = 1'b0;
    apply_setup(pick_index(), 32'h0000_0000, 32'h0000_0000);
    run_random(30);
    apply_setup(pick_index(), ID_W'($urandom_range(0, 15)), 32'h0000_00FF);
    run_random(70);
    apply_setup(pick_index(), ID_W'($urandom_range(0, 15)), ID_W'($urandom));
    run_random(24);

    settle();
    repeat (ENTRIES + 16) @(posedge clk);
    if (fail_count == 0 && awaiting == 0) begin
      $display("receive_id_index_table verification clean");
    end else begin
      $display("receive_id_index_table verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rit_pkg.sv
rtl/rit_mem.sv
rtl/rit_cfg.sv
rtl/rit_ctrl.sv
rtl/receive_id_index_table.sv
rtl/rit_chk.sv
tb/receive_id_index_table_checker.sv
tb/tb_receive_id_index_table.sv
